// ===== hw/rtl/debounced_long_press_detector_top_assert.svh =====
// Assertion macros for the debounced long-press detector.
`ifndef DEBOUNCED_LONG_PRESS_DETECTOR_TOP_ASSERT_SVH
`define DEBOUNCED_LONG_PRESS_DETECTOR_TOP_ASSERT_SVH

`ifndef SYNTH

// Checks prop at every rising edge of clk while reset is released.
`define DLPD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks prop at every rising edge of clk, reset included.
`define DLPD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DLPD_ASSERT(label, clk, rst_n, prop, msg)
`define DLPD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/dlpd_pkg.sv =====
// Types, constants and register indexes of the debounced long-press detector.
`timescale 1ns / 1ps

package dlpd_pkg;

  localparam int unsigned DEBOUNCE_W = 16;
  localparam int unsigned HOLD_W = 20;
  localparam int unsigned TOTAL_W = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam int unsigned PRESS_COUNT_WIDTH_DEF = 16;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_TARGET_RST = 16'd50;
  localparam logic [HOLD_W-1:0] LONG_PRESS_TICKS_RST = 20'd37500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TARGET  = 1'b0,
    REG_LONG_PRESS_TICKS = 1'b1
  } reg_idx_e;

  // One result item, packed with the last field in the lowest bits.
  typedef struct packed {
    logic [TOTAL_W-1:0] press_total;
    logic               pressed_sticky;
    logic               long_press;
    logic               press_registered;
  } res_t;

  // State visible to the checks in the top level.
  typedef struct packed {
    logic               edge_armed;
    logic               deb_running;
    logic               pressed_flag;
    logic [TOTAL_W-1:0] press_total;
  } sts_t;

endpackage

// ===== hw/rtl/debounced_long_press_detector_top.sv =====
// Top level of the debounced long-press detector.
//
//   channel  direction  transfer when              payload
//   s_axis   in         s_axis_tvalid & tready     tdata[0] level
//   m_axis   out        m_axis_tvalid & tready     tdata[0] press_registered,
//                                                  [1] long_press, [2] pressed_sticky,
//                                                  [18:3] press_total
//   cfg      in         cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One tick per cycle while the output is not stalled: a sample sits in the
// input register, the state update runs in one pass, and the result lands in
// the output register, from which it can transfer out.
// Reset restores the register defaults and the idle state. A stall at the
// output holds the input register, and input ready drops only when both
// registers are full and the output is not taken.
`timescale 1ns / 1ps
`include "debounced_long_press_detector_top_assert.svh"

module debounced_long_press_detector_top import dlpd_pkg::*; #(
  parameter int unsigned PressCountWidth = PRESS_COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [0] level, [7:1] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] press_registered, [1] long_press, [2] pressed_sticky, [18:3] press_total,
  // [23:19] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic s1_valid_q, s1_valid_d;
  logic s1_level_q;
  logic advance;
  logic out_space;
  logic s_xfer;
  res_t core_res;
  res_t out_res;
  sts_t sts;

  assign advance = s1_valid_q && out_space;
  assign s_axis_tready = !s1_valid_q || advance;
  assign s_xfer = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_xfer) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      s1_level_q <= s_axis_tdata[0];
    end
  end

  dlpd_core #(
    .PressCountWidth(PressCountWidth)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .step_i    (advance),
    .level_i   (s1_level_q),
    .res_o     (core_res),
    .sts_o     (sts)
  );

  dlpd_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance),
    .data_i (core_res),
    .ready_i(m_axis_tready),
    .space_o(out_space),
    .valid_o(m_axis_tvalid),
    .data_o (out_res)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - $bits(res_t))'(0), out_res};

  // Edge detection is off only while a debounce count is running.
  `DLPD_ASSERT(a_disarm_runs, clk_i, rst_ni, !sts.edge_armed |-> sts.deb_running, "disarmed without debounce count")
  `DLPD_ASSERT(a_sticky_holds, clk_i, rst_ni, sts.pressed_flag |=> sts.pressed_flag, "pressed flag cleared")
  `DLPD_ASSERT(a_confirm_sticky, clk_i, rst_ni, m_axis_tvalid && out_res.press_registered |-> out_res.pressed_sticky, "press without sticky flag")
  `DLPD_ASSERT(a_stall_holds, clk_i, rst_ni, s1_valid_q && !advance |=> $stable(sts.press_total), "state moved while stalled")

endmodule

// ===== hw/rtl/dlpd_core.sv =====
// Per-tick debounce, hold counter and long-press state update.
`timescale 1ns / 1ps

module dlpd_core import dlpd_pkg::*; #(
  parameter int unsigned PressCountWidth = PRESS_COUNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  step_i,
  input  logic                  level_i,
  output res_t                  res_o,
  output sts_t                  sts_o
);

  logic [DEBOUNCE_W-1:0]      target_q, target_d;
  logic [HOLD_W-1:0]          lp_ticks_q, lp_ticks_d;
  logic                       prev_q, prev_d;
  logic                       armed_q, armed_d;
  logic [DEBOUNCE_W-1:0]      deb_q, deb_d;
  logic [HOLD_W-1:0]          hold_q, hold_d;
  logic                       det_q, det_d;
  logic                       flag_q, flag_d;
  logic [PressCountWidth-1:0] cnt_q, cnt_d;
  logic                       confirm;
  logic                       longp;
  logic                       edge_hit;

  always_comb begin
    target_d = target_q;
    lp_ticks_d = lp_ticks_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_DEBOUNCE_TARGET:  target_d = cfg_data_i[DEBOUNCE_W-1:0];
        REG_LONG_PRESS_TICKS: lp_ticks_d = cfg_data_i[HOLD_W-1:0];
        default:              target_d = target_q;
      endcase
    end
  end

  always_comb begin
    deb_d = deb_q;
    armed_d = armed_q;
    hold_d = hold_q;
    det_d = det_q;
    flag_d = flag_q;
    cnt_d = cnt_q;
    confirm = 1'b0;
    longp = 1'b0;

    // A running debounce count saturates; a low sample at or past the target confirms.
    if (deb_q != '0) begin
      deb_d = (deb_q != '1) ? deb_q + 16'd1 : deb_q;
      if (deb_q >= target_q && !level_i) begin
        confirm = 1'b1;
        flag_d = 1'b1;
        det_d = 1'b1;
        cnt_d = cnt_q + 1'b1;
        deb_d = '0;
        armed_d = 1'b1;
      end
    end

    // Edge detection sees the arming done by a confirm on this same tick.
    edge_hit = armed_d && prev_q && !level_i;
    if (edge_hit) begin
      armed_d = 1'b0;
      deb_d = 16'd1;
      hold_d = '0;
    end else if (hold_q != '1) begin
      hold_d = hold_q + 20'd1;
    end

    if (det_d && hold_d >= lp_ticks_q && !level_i) begin
      longp = 1'b1;
      det_d = 1'b0;
    end

    prev_d = level_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= DEBOUNCE_TARGET_RST;
      lp_ticks_q <= LONG_PRESS_TICKS_RST;
    end else begin
      target_q <= target_d;
      lp_ticks_q <= lp_ticks_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b1;
      armed_q <= 1'b1;
      deb_q <= '0;
      hold_q <= '0;
      det_q <= 1'b0;
      flag_q <= 1'b0;
      cnt_q <= '0;
    end else if (step_i) begin
      prev_q <= prev_d;
      armed_q <= armed_d;
      deb_q <= deb_d;
      hold_q <= hold_d;
      det_q <= det_d;
      flag_q <= flag_d;
      cnt_q <= cnt_d;
    end
  end

  assign res_o.press_registered = confirm;
  assign res_o.long_press = longp;
  assign res_o.pressed_sticky = flag_d;
  assign res_o.press_total = TOTAL_W'(cnt_d);

  assign sts_o.edge_armed = armed_q;
  assign sts_o.deb_running = (deb_q != '0);
  assign sts_o.pressed_flag = flag_q;
  assign sts_o.press_total = TOTAL_W'(cnt_q);

endmodule

// ===== hw/rtl/dlpd_out_reg.sv =====
// Result register of the detector with its output handshake.
`timescale 1ns / 1ps

module dlpd_out_reg import dlpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t data_i,
  input  logic ready_i,
  output logic space_o,
  output logic valid_o,
  output res_t data_o
);

  logic valid_q, valid_d;
  res_t data_q;

  // The register frees up in the same cycle its item transfers out.
  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

endmodule
